### hdl/tppc_pkg.sv
// Types and constants for the two-point pinch classifier.
// No dependencies; used by the interfaces and all modules.
package tppc_pkg;

	localparam int COORD_W   = 16;
	localparam int DIST_W    = 17;
	localparam int KIND_W    = 3;
	localparam int COUNT_W   = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [KIND_W-1:0] KIND_BEGIN  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd2;
	localparam logic [KIND_W-1:0] KIND_END    = 3'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CANCEL  = 2'd1;

	localparam logic [DIST_W-1:0]  THRESH_RESET = 17'd100;
	localparam logic [COUNT_W-1:0] PINCH_POINTS = 4'd2;

	typedef enum logic [1:0] {
		DIR_IDLE,
		DIR_UNDECIDED,
		DIR_IN,
		DIR_OUT
	} dir_t;

	typedef enum logic [2:0] {
		V_IGNORE,
		V_MAYBE,
		V_TRIGGER,
		V_CANCEL,
		V_FINISH
	} verdict_t;

	typedef struct packed {
		verdict_t verdict;
		dir_t     mode;
	} tppc_result_t;

endpackage

### hdl/tppc_ifs.sv
// Valid/ready channel interfaces: touch events, verdicts, config writes.
// Depends on tppc_pkg.
interface tppc_evt_if;
	import tppc_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         event_kind;
	logic [COUNT_W-1:0]        point_count;
	logic signed [COORD_W-1:0] first_x;
	logic signed [COORD_W-1:0] first_y;
	logic signed [COORD_W-1:0] second_x;
	logic signed [COORD_W-1:0] second_y;

	modport source (output valid, event_kind, point_count, first_x, first_y,
		second_x, second_y, input ready);
	modport sink (input valid, event_kind, point_count, first_x, first_y,
		second_x, second_y, output ready);
endinterface

interface tppc_res_if;
	import tppc_pkg::*;
	logic              valid;
	logic              ready;
	logic [2:0]        verdict;
	logic [1:0]        zoom_mode;
	logic [DIST_W-1:0] point_distance;

	modport source (output valid, verdict, zoom_mode, point_distance, input ready);
	modport sink (input valid, verdict, zoom_mode, point_distance, output ready);
endinterface

interface tppc_cfg_if;
	import tppc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIST_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hdl/tppc_dist.sv
// Manhattan distance between two signed points.
// Depends on tppc_pkg.
module tppc_dist (
	input  logic signed [tppc_pkg::COORD_W-1:0] ax,
	input  logic signed [tppc_pkg::COORD_W-1:0] ay,
	input  logic signed [tppc_pkg::COORD_W-1:0] bx,
	input  logic signed [tppc_pkg::COORD_W-1:0] by,
	output logic        [tppc_pkg::DIST_W-1:0]  pt_dist
);
	import tppc_pkg::*;

	logic signed [COORD_W:0] dx, dy;
	logic [COORD_W-1:0] adx, ady;

	always_comb begin
		dx  = {ax[COORD_W-1], ax} - {bx[COORD_W-1], bx};
		dy  = {ay[COORD_W-1], ay} - {by[COORD_W-1], by};
		adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
		ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
		pt_dist = {1'b0, adx} + {1'b0, ady};
	end

endmodule

### hdl/tppc_fsm.sv
// Pinch direction state and verdict decision for one event per step.
// Depends on tppc_pkg.
module tppc_fsm (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic [tppc_pkg::KIND_W-1:0]     kind,
	input  logic [tppc_pkg::COUNT_W-1:0]    count,
	input  logic [tppc_pkg::DIST_W-1:0]     pt_dist,
	input  logic [tppc_pkg::DIST_W-1:0]     trig_thr,
	input  logic [tppc_pkg::DIST_W-1:0]     cancel_thr,
	output tppc_pkg::tppc_result_t          res
);
	import tppc_pkg::*;

	dir_t              dir_q, dir_d;
	logic [DIST_W-1:0] start_q, start_d;
	logic [DIST_W-1:0] ref_q, ref_d;
	logic [DIST_W-1:0] base;
	logic signed [DIST_W:0] diff;
	logic [DIST_W-1:0] mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q   <= DIR_IDLE;
			start_q <= '0;
			ref_q   <= '0;
		end else if (step) begin
			dir_q   <= dir_d;
			start_q <= start_d;
			ref_q   <= ref_d;
		end
	end

	always_comb begin
		base = (dir_q == DIR_UNDECIDED) ? start_q : ref_q;
		diff = {1'b0, pt_dist} - {1'b0, base};
		mag  = diff[DIST_W] ? DIST_W'(-diff) : diff[DIST_W-1:0];

		dir_d       = dir_q;
		start_d     = start_q;
		ref_d       = ref_q;
		res.verdict = V_IGNORE;

		case (kind)
			KIND_BEGIN: begin
				res.verdict = V_MAYBE;
			end
			KIND_UPDATE: begin
				if (count == PINCH_POINTS) begin
					case (dir_q)
						DIR_IDLE: begin
							start_d     = pt_dist;
							ref_d       = pt_dist;
							dir_d       = DIR_UNDECIDED;
							res.verdict = V_TRIGGER;
						end
						DIR_UNDECIDED: begin
							if (mag > trig_thr) begin
								ref_d       = pt_dist;
								dir_d       = diff[DIST_W] ? DIR_OUT : DIR_IN;
								res.verdict = V_TRIGGER;
							end else begin
								res.verdict = V_MAYBE;
							end
						end
						default: begin
							if ((dir_q == DIR_IN && !diff[DIST_W] && diff != '0) ||
							    (dir_q == DIR_OUT && diff[DIST_W]))
								res.verdict = V_TRIGGER;
							else if (mag < cancel_thr)
								res.verdict = V_IGNORE;
							else
								res.verdict = V_CANCEL;
						end
					endcase
				end
			end
			KIND_CANCEL: begin
				dir_d       = DIR_IDLE;
				res.verdict = V_CANCEL;
			end
			KIND_END: begin
				dir_d       = DIR_IDLE;
				res.verdict = V_FINISH;
			end
			default: begin
				res.verdict = V_IGNORE;
			end
		endcase

		res.mode = dir_d;
	end

endmodule

### hdl/two_point_pinch_classifier_core.sv
// Top level of the two-point pinch classifier: input register, decision, result register.
// Depends on tppc_pkg, tppc_ifs, tppc_dist, tppc_fsm.
//
//   port  modport  carries
//   evt   sink     event_kind, point_count, first_x/y, second_x/y
//   res   source   verdict, zoom_mode, point_distance
//   cfg   sink     index, data (0 trigger_threshold, 1 cancel_threshold)
//
// One event per cycle while results are taken; results come from the result register.
// Distance and decision run in the cycle between the input and result registers.
// A stalled result holds; the input register still takes an event while it is
// empty or the result register is free or being taken. Reset clears state,
// thresholds to 100.
module two_point_pinch_classifier_core (
	input logic      clk,
	input logic      arst_n,
	tppc_evt_if.sink   evt,
	tppc_res_if.source res,
	tppc_cfg_if.sink   cfg
);
	import tppc_pkg::*;

	logic [DIST_W-1:0] trig_q, cancel_q;

	logic                      valid_s1;
	logic [KIND_W-1:0]         kind_s1;
	logic [COUNT_W-1:0]        count_s1;
	logic signed [COORD_W-1:0] ax_s1, ay_s1, bx_s1, by_s1;

	logic              out_valid_q;
	verdict_t          verdict_q;
	dir_t              mode_q;
	logic [DIST_W-1:0] dist_q;

	logic              adv, step;
	logic [DIST_W-1:0] pt_dist;
	tppc_result_t      dec;

	assign cfg.ready = 1'b1;
	assign adv       = !out_valid_q || res.ready;
	assign step      = valid_s1 && adv;
	assign evt.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q   <= THRESH_RESET;
			cancel_q <= THRESH_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_TRIGGER)
				trig_q <= cfg.data;
			else if (cfg.index == CFG_CANCEL)
				cancel_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			kind_s1  <= evt.event_kind;
			count_s1 <= evt.point_count;
			ax_s1    <= evt.first_x;
			ay_s1    <= evt.first_y;
			bx_s1    <= evt.second_x;
			by_s1    <= evt.second_y;
		end
	end

	tppc_dist u_dist (
		.ax      (ax_s1),
		.ay      (ay_s1),
		.bx      (bx_s1),
		.by      (by_s1),
		.pt_dist (pt_dist)
	);

	tppc_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.kind       (kind_s1),
		.count      (count_s1),
		.pt_dist    (pt_dist),
		.trig_thr   (trig_q),
		.cancel_thr (cancel_q),
		.res        (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			verdict_q <= dec.verdict;
			mode_q    <= dec.mode;
			dist_q    <= pt_dist;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.verdict        = verdict_q;
	assign res.zoom_mode      = mode_q;
	assign res.point_distance = dist_q;

endmodule

### verif/two_point_pinch_classifier_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for two_point_pinch_classifier_core: directed and random touch events,
// an in-bench pinch predictor and in-order result compare. Depends on tppc_pkg, tppc_ifs.
module two_point_pinch_classifier_core_tb;
	import tppc_pkg::*;

	localparam logic [KIND_W-1:0]    KIND_OTHER  = 3'd4;
	localparam logic [KIND_W-1:0]    KIND_LAST   = 3'd7;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam int MAX_SPAN  = 131070;
	localparam int THR_MAX   = 131071;
	localparam int PHASES    = 6;
	localparam int PHASE_LEN = 275;

	typedef struct {
		logic [KIND_W-1:0]         kind;
		logic [COUNT_W-1:0]        count;
		logic signed [COORD_W-1:0] fx;
		logic signed [COORD_W-1:0] fy;
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
	} touch_event_t;

	typedef struct packed {
		verdict_t          verdict;
		dir_t              mode;
		logic [DIST_W-1:0] point_distance;
	} pinch_result_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	tppc_evt_if evt_ch();
	tppc_res_if res_ch();
	tppc_cfg_if cfg_ch();

	two_point_pinch_classifier_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state and thresholds
	dir_t              zoom_dir;
	logic [DIST_W-1:0] start_span;
	logic [DIST_W-1:0] ref_span;
	logic [DIST_W-1:0] trig_thr;
	logic [DIST_W-1:0] cancel_thr;

	touch_event_t  pending_events[$];
	pinch_result_t pinch_expected[$];
	int            errors = 0;

	function automatic pinch_result_t classify_event(logic [KIND_W-1:0] kind,
			logic [COUNT_W-1:0] count, logic signed [COORD_W-1:0] fx,
			logic signed [COORD_W-1:0] fy, logic signed [COORD_W-1:0] sx,
			logic signed [COORD_W-1:0] sy);
		pinch_result_t r;
		int dx, dy, span, delta, mag;
		dx = int'(fx) - int'(sx);
		dy = int'(fy) - int'(sy);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		span = dx + dy;
		r.verdict = V_IGNORE;
		case (kind)
			KIND_BEGIN: r.verdict = V_MAYBE;
			KIND_UPDATE: begin
				if (count == PINCH_POINTS) begin
					case (zoom_dir)
						DIR_IDLE: begin
							start_span = DIST_W'(span);
							ref_span = DIST_W'(span);
							zoom_dir = DIR_UNDECIDED;
							r.verdict = V_TRIGGER;
						end
						DIR_UNDECIDED: begin
							delta = span - int'(start_span);
							mag = delta < 0 ? -delta : delta;
							if (mag > int'(trig_thr)) begin
								ref_span = DIST_W'(span);
								zoom_dir = delta > 0 ? DIR_IN : DIR_OUT;
								r.verdict = V_TRIGGER;
							end else begin
								r.verdict = V_MAYBE;
							end
						end
						default: begin
							delta = span - int'(ref_span);
							mag = delta < 0 ? -delta : delta;
							if ((zoom_dir == DIR_IN && delta > 0) ||
									(zoom_dir == DIR_OUT && delta < 0))
								r.verdict = V_TRIGGER;
							else if (mag < int'(cancel_thr))
								r.verdict = V_IGNORE;
							else
								r.verdict = V_CANCEL;
						end
					endcase
				end
			end
			KIND_CANCEL: begin
				zoom_dir = DIR_IDLE;
				r.verdict = V_CANCEL;
			end
			KIND_END: begin
				zoom_dir = DIR_IDLE;
				r.verdict = V_FINISH;
			end
			default: r.verdict = V_IGNORE;
		endcase
		r.mode = zoom_dir;
		r.point_distance = DIST_W'(span);
		return r;
	endfunction

	// two points whose Manhattan distance is span, placed at random
	function automatic touch_event_t pinch_points(logic [KIND_W-1:0] kind,
			logic [COUNT_W-1:0] count, int span);
		touch_event_t ev;
		int dx, dy, x0, y0;
		dx = $urandom_range(span > 65535 ? span - 65535 : 0, span < 65535 ? span : 65535);
		dy = span - dx;
		x0 = int'($urandom_range(0, 65535 - dx)) - 32768;
		y0 = int'($urandom_range(0, 65535 - dy)) - 32768;
		ev.kind = kind;
		ev.count = count;
		if ($urandom_range(0, 1)) begin
			ev.fx = COORD_W'(x0);
			ev.sx = COORD_W'(x0 + dx);
		end else begin
			ev.fx = COORD_W'(x0 + dx);
			ev.sx = COORD_W'(x0);
		end
		if ($urandom_range(0, 1)) begin
			ev.fy = COORD_W'(y0);
			ev.sy = COORD_W'(y0 + dy);
		end else begin
			ev.fy = COORD_W'(y0 + dy);
			ev.sy = COORD_W'(y0);
		end
		return ev;
	endfunction

	task automatic push_gesture();
		int span, step, stepmax, dirn, n;
		stepmax = int'(trig_thr > cancel_thr ? trig_thr : cancel_thr) * 2 + 8;
		if (stepmax > MAX_SPAN) stepmax = MAX_SPAN;
		span = $urandom_range(0, MAX_SPAN);
		if ($urandom_range(0, 3) != 0)
			pending_events.push_back(pinch_points(KIND_BEGIN,
				COUNT_W'($urandom_range(0, 15)), span));
		pending_events.push_back(pinch_points(KIND_UPDATE, PINCH_POINTS, span));
		n = $urandom_range(2, 12);
		dirn = $urandom_range(0, 1) ? 1 : -1;
		repeat (n) begin
			step = $urandom_range(0, stepmax);
			if ($urandom_range(0, 4) == 0) step = -step;
			span += dirn * step;
			if (span < 0) span = 0;
			if (span > MAX_SPAN) span = MAX_SPAN;
			if ($urandom_range(0, 9) == 0)
				pending_events.push_back(pinch_points(KIND_UPDATE,
					COUNT_W'($urandom_range(0, 15)), span));
			else
				pending_events.push_back(pinch_points(KIND_UPDATE, PINCH_POINTS, span));
		end
		case ($urandom_range(0, 7))
			0, 1, 2: pending_events.push_back(pinch_points(KIND_END,
				COUNT_W'($urandom_range(0, 15)), span));
			3, 4, 5: pending_events.push_back(pinch_points(KIND_CANCEL,
				COUNT_W'($urandom_range(0, 15)), span));
			default: ;
		endcase
	endtask

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == CFG_TRIGGER)
			trig_thr = val;
		else if (idx == CFG_CANCEL)
			cancel_thr = val;
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_events.size() != 0 || evt_ch.valid || pinch_expected.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// event driver: bursts with random gaps
	touch_event_t nxt;
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (evt_ch.valid && evt_ch.ready)
				pinch_expected.push_back(classify_event(evt_ch.event_kind, evt_ch.point_count,
					evt_ch.first_x, evt_ch.first_y, evt_ch.second_x, evt_ch.second_y));
			if (!evt_ch.valid || evt_ch.ready) begin
				if (gap_left > 0 || pending_events.size() == 0) begin
					if (gap_left > 0) gap_left--;
					evt_ch.valid <= 1'b0;
				end else begin
					nxt = pending_events.pop_front();
					evt_ch.valid       <= 1'b1;
					evt_ch.event_kind  <= nxt.kind;
					evt_ch.point_count <= nxt.count;
					evt_ch.first_x     <= nxt.fx;
					evt_ch.first_y     <= nxt.fy;
					evt_ch.second_x    <= nxt.sx;
					evt_ch.second_y    <= nxt.sy;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 48);
						gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
					end
				end
			end
		end
	end

	// result monitor and receiver stalls
	pinch_result_t want;
	rx_mode_t      rx_mode = RX_OPEN;
	logic [31:0]   stall_pat = '1;
	int            rx_cycles = 0;
	int            hold_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (pinch_expected.size() == 0) begin
					report_mismatch("result with no event pending", int'(res_ch.verdict), 0);
				end else begin
					want = pinch_expected.pop_front();
					if (res_ch.verdict !== want.verdict)
						report_mismatch("verdict", int'(res_ch.verdict), int'(want.verdict));
					if (res_ch.zoom_mode !== want.mode)
						report_mismatch("zoom_mode", int'(res_ch.zoom_mode), int'(want.mode));
					if (res_ch.point_distance !== want.point_distance)
						report_mismatch("point_distance", int'(res_ch.point_distance),
							int'(want.point_distance));
				end
			end
			rx_cycles++;
			if (rx_cycles == 700 || rx_cycles == 2600)
				hold_left = 160;
			if (rx_cycles % 96 == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				stall_pat = $urandom;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN:   res_ch.ready <= 1'b1;
					RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: res_ch.ready <= ($urandom_range(0, 7) != 0);
					default: begin
						res_ch.ready <= stall_pat[0];
						stall_pat = {stall_pat[0], stall_pat[31:1]};
					end
				endcase
			end
		end
	end

	initial begin
		#5_000_000;
		$display("two_point_pinch_classifier_core verification failed");
		$finish;
	end

	initial begin
		touch_event_t ev;
		int phase, k;
		arst_n = 1'b0;
		evt_ch.valid = 1'b0;
		evt_ch.event_kind = '0;
		evt_ch.point_count = '0;
		evt_ch.first_x = '0;
		evt_ch.first_y = '0;
		evt_ch.second_x = '0;
		evt_ch.second_y = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		zoom_dir = DIR_IDLE;
		start_span = '0;
		ref_span = '0;
		trig_thr = THRESH_RESET;
		cancel_thr = THRESH_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: corner coordinates, ignored kinds/counts, lock both ways
		ev = '{KIND_BEGIN, PINCH_POINTS, 16'sh8000, 16'sd32767, 16'sd32767, 16'sh8000};
		pending_events.push_back(ev);
		pending_events.push_back(pinch_points(KIND_UPDATE, 4'd0, 500));
		pending_events.push_back(pinch_points(KIND_UPDATE, 4'd15, 500));
		for (k = KIND_OTHER; k <= KIND_LAST; k++)
			pending_events.push_back(pinch_points(KIND_W'(k), PINCH_POINTS, 700));
		pending_events.push_back(pinch_points(KIND_UPDATE, PINCH_POINTS, 1000));
		pending_events.push_back(pinch_points(KIND_UPDATE, PINCH_POINTS, 1100));
		pending_events.push_back(pinch_points(KIND_UPDATE, PINCH_POINTS, 1101));
		pending_events.push_back(pinch_points(KIND_UPDATE, PINCH_POINTS, 1200));
		pending_events.push_back(pinch_points(KIND_UPDATE, PINCH_POINTS, 1101));
		pending_events.push_back(pinch_points(KIND_UPDATE, PINCH_POINTS, 1002));
		pending_events.push_back(pinch_points(KIND_UPDATE, PINCH_POINTS, 1001));
		pending_events.push_back(pinch_points(KIND_UPDATE, PINCH_POINTS, 1300));
		pending_events.push_back(pinch_points(KIND_END, PINCH_POINTS, 1300));
		ev = '{KIND_UPDATE, PINCH_POINTS, 16'sd32767, 16'sh8000, 16'sh8000, 16'sd32767};
		pending_events.push_back(ev);
		ev = '{KIND_UPDATE, PINCH_POINTS, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
		pending_events.push_back(ev);
		pending_events.push_back(pinch_points(KIND_UPDATE, PINCH_POINTS, 0));
		pending_events.push_back(pinch_points(KIND_UPDATE, PINCH_POINTS, 200));
		pending_events.push_back(pinch_points(KIND_CANCEL, PINCH_POINTS, 200));
		pending_events.push_back(pinch_points(KIND_CANCEL, 4'd0, 0));
		pending_events.push_back(pinch_points(KIND_END, 4'd0, 0));
		pending_events.push_back(pinch_points(KIND_UPDATE, PINCH_POINTS, 500));
		pending_events.push_back(pinch_points(KIND_UPDATE, PINCH_POINTS, 399));
		pending_events.push_back(pinch_points(KIND_UPDATE, PINCH_POINTS, 300));
		pending_events.push_back(pinch_points(KIND_END, PINCH_POINTS, 300));

		for (phase = 0; phase < PHASES; phase++) begin
			if (phase != 0) begin
				wait_drained();
				case (phase)
					1: begin
						write_reg(CFG_SPARE_A, '1);
						write_reg(CFG_SPARE_B, 17'h0A5A5);
						write_reg(CFG_TRIGGER, '0);
						write_reg(CFG_CANCEL, '0);
					end
					2: begin
						write_reg(CFG_TRIGGER, DIST_W'(THR_MAX));
						write_reg(CFG_CANCEL, DIST_W'(THR_MAX));
					end
					3: begin
						write_reg(CFG_TRIGGER, 17'd37);
						write_reg(CFG_CANCEL, 17'd900);
					end
					4: begin
						write_reg(CFG_TRIGGER, DIST_W'($urandom_range(0, 5000)));
						write_reg(CFG_CANCEL, DIST_W'($urandom_range(0, 5000)));
					end
					default: begin
						write_reg(CFG_TRIGGER, 17'd2000);
						write_reg(CFG_CANCEL, 17'd5);
					end
				endcase
			end
			k = 0;
			while (k < PHASE_LEN) begin
				if ($urandom_range(0, 6) == 0) begin
					ev.kind  = KIND_W'($urandom_range(0, 7));
					ev.count = COUNT_W'($urandom_range(0, 15));
					ev.fx    = COORD_W'($urandom);
					ev.fy    = COORD_W'($urandom);
					ev.sx    = COORD_W'($urandom);
					ev.sy    = COORD_W'($urandom);
					pending_events.push_back(ev);
					k++;
				end else begin
					k -= pending_events.size();
					push_gesture();
					k += pending_events.size();
				end
			end
		end
		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0 && pinch_expected.size() == 0)
			$display("two_point_pinch_classifier_core verification clean");
		else
			$display("two_point_pinch_classifier_core verification failed");
		$finish;
	end

endmodule
